/* rtl/sdnv_codec_macros.svh */
// Assertion helpers shared by the codec modules.
// Each one expects clk and rst_n in scope.
`ifndef SDNV_CODEC_MACROS_SVH
`define SDNV_CODEC_MACROS_SVH

`ifndef SYNTHESIS
`define SDNV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SDNV_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SDNV_ASSERT(lbl, prop, msg)
`define SDNV_NEVER(lbl, cond, msg)
`endif

`endif

/* rtl/sdnv_pkg.sv */
package sdnv_pkg;

    // Field widths
    localparam int VALUE_W   = 32;
    localparam int BYTE_W    = 8;
    localparam int GROUP_W   = 7;
    localparam int CNT_W     = 3;
    localparam int NBYTES_W  = 3;
    localparam int MAX_BYTES = 5;

    // Action codes
    localparam logic ACT_DECODE = 1'b0;
    localparam logic ACT_ENCODE = 1'b1;

    // Status codes
    localparam logic STAT_OK      = 1'b0;
    localparam logic STAT_TOO_LONG = 1'b1;

    localparam logic [BYTE_W-1:0] CONT_FLAG = 8'h80;

    typedef struct packed {
        logic               action;
        logic [BYTE_W-1:0]  in_byte;
        logic [VALUE_W-1:0] in_value;
    } sdnv_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [VALUE_W-1:0] out_value;
        logic               value_ready;
        logic               status;
        logic               last;
    } sdnv_rsp_t;

    // Classified item passed from front to back end
    typedef struct packed {
        logic                encode;
        logic [VALUE_W-1:0]  value;
        logic                value_ready;
        logic                status;
        logic [NBYTES_W-1:0] nbytes;
    } sdnv_cmd_t;

    // Number of 7-bit groups needed, at least one
    function automatic logic [NBYTES_W-1:0] enc_nbytes(input logic [VALUE_W-1:0] v);
        logic [NBYTES_W-1:0] n;
        begin
            if (v[31:28] != '0)
                n = 3'd5;
            else if (v[27:21] != '0)
                n = 3'd4;
            else if (v[20:14] != '0)
                n = 3'd3;
            else if (v[13:7] != '0)
                n = 3'd2;
            else
                n = 3'd1;
            return n;
        end
    endfunction

    // 7-bit group k (1 = least significant) of v
    function automatic logic [GROUP_W-1:0] enc_group(input logic [VALUE_W-1:0] v,
                                                     input logic [NBYTES_W-1:0] k);
        logic [GROUP_W-1:0] g;
        begin
            case (k)
                3'd5:    g = {3'b000, v[31:28]};
                3'd4:    g = v[27:21];
                3'd3:    g = v[20:14];
                3'd2:    g = v[13:7];
                default: g = v[6:0];
            endcase
            return g;
        end
    endfunction

endpackage

/* rtl/sdnv_codec.sv */
// SDNV codec, 32-bit. One item is taken per clock whenever full is low. A decode
// item (action 0) gives one result; an encode item (action 1) gives one to five
// bytes, most significant group first, one per clock while pop keeps up. The
// front end updates the decode state and sizes the encode at push time, so it
// never stalls on its own; items then wait in a FIFO_DEPTH-entry queue for the
// back end, whose single output register sets the result rate: one result per
// cycle while pop keeps up; an encode holds it until its last byte is out. A
// pushed item is queued, then registered. No clearing pass after reset.
module sdnv_codec #(
    parameter int MAX_CONTINUATION = 4,
    parameter int FIFO_DEPTH       = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  sdnv_pkg::sdnv_req_t req,
    output logic                empty,
    input  logic                pop,
    output sdnv_pkg::sdnv_rsp_t rsp
);
    import sdnv_pkg::*;

    sdnv_cmd_t front_cmd, head;
    logic      accept, head_pop, head_empty;

    assign accept = push && !full;

    sdnv_front #(
        .MAX_CONTINUATION(MAX_CONTINUATION)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .cmd    (front_cmd)
    );

    sdnv_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept),
        .wdata (front_cmd),
        .rd    (head_pop),
        .rdata (head),
        .full  (full),
        .empty (head_empty)
    );

    sdnv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .rsp        (rsp)
    );

endmodule

/* rtl/sdnv_fifo.sv */
`include "sdnv_codec_macros.svh"

module sdnv_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  sdnv_pkg::sdnv_cmd_t wdata,
    input  logic              rd,
    output sdnv_pkg::sdnv_cmd_t rdata,
    output logic              full,
    output logic              empty
);
    import sdnv_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W_F = PTR_W + 1;

    sdnv_cmd_t            mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W_F-1:0]   cnt_reg, cnt_next;
    logic                 do_wr, do_rd;

    assign full  = (cnt_reg == CNT_W_F'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wdata;
    end

    `SDNV_NEVER(a_fifo_over, cnt_reg > CNT_W_F'(DEPTH), "fifo count above depth")
    `SDNV_ASSERT(a_fifo_ptrs, (cnt_reg == '0 || cnt_reg == CNT_W_F'(DEPTH)) |-> wr_ptr_reg == rd_ptr_reg, "fifo pointers disagree with count")
    `SDNV_ASSERT(a_fifo_wr, (do_wr && !do_rd) |=> cnt_reg == $past(cnt_reg) + 1'b1, "fifo write not counted")

endmodule

/* rtl/sdnv_front.sv */
module sdnv_front #(
    parameter int MAX_CONTINUATION = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  sdnv_pkg::sdnv_req_t req,
    output sdnv_pkg::sdnv_cmd_t cmd
);
    import sdnv_pkg::*;

    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] acc_shift;
    logic [CNT_W:0]     cnt_inc;

    assign acc_shift = {acc_reg[VALUE_W-GROUP_W-1:0], req.in_byte[GROUP_W-1:0]};
    assign cnt_inc   = {1'b0, cnt_reg} + 1'b1;

    // Classify the item and update the decode state
    always_comb
    begin
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        cmd.encode      = 1'b0;
        cmd.value       = '0;
        cmd.value_ready = 1'b0;
        cmd.status      = STAT_OK;
        cmd.nbytes      = 3'd1;
        if (req.action == ACT_ENCODE)
        begin
            cmd.encode = 1'b1;
            cmd.value  = req.in_value;
            cmd.nbytes = enc_nbytes(req.in_value);
        end
        else if (!req.in_byte[BYTE_W-1])
        begin
            // final byte of a number
            cmd.value       = acc_shift;
            cmd.value_ready = 1'b1;
            acc_next        = '0;
            cnt_next        = '0;
        end
        else if (cnt_inc > (CNT_W+1)'(MAX_CONTINUATION))
        begin
            // too many continuation bytes
            cmd.status = STAT_TOO_LONG;
            acc_next   = '0;
            cnt_next   = '0;
        end
        else
        begin
            acc_next = acc_shift;
            cnt_next = cnt_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* rtl/sdnv_back.sv */
`include "sdnv_codec_macros.svh"

module sdnv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sdnv_pkg::sdnv_cmd_t head,
    input  logic                head_empty,
    output logic                head_pop,
    input  logic                pop,
    output logic                empty,
    output sdnv_pkg::sdnv_rsp_t rsp
);
    import sdnv_pkg::*;

    logic                busy_reg, busy_next;
    logic [NBYTES_W-1:0] rem_reg, rem_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                out_valid_reg;
    sdnv_rsp_t           rsp_reg, rsp_next;
    logic                adv, src_valid;
    logic [NBYTES_W-1:0] src_n;
    logic [VALUE_W-1:0]  src_val;
    logic                src_enc;

    assign adv       = !out_valid_reg || pop;
    assign src_valid = busy_reg || !head_empty;
    assign src_n     = busy_reg ? rem_reg : head.nbytes;
    assign src_val   = busy_reg ? val_reg : head.value;
    assign src_enc   = busy_reg || head.encode;
    assign head_pop  = adv && !busy_reg && !head_empty;
    assign empty     = !out_valid_reg;
    assign rsp       = rsp_reg;

    // Build the next result and step through encode bytes
    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        val_next  = val_reg;
        rsp_next  = rsp_reg;
        if (adv && src_valid)
        begin
            if (src_enc)
            begin
                rsp_next.out_byte    = {(src_n != 3'd1), enc_group(src_val, src_n)};
                rsp_next.out_value   = '0;
                rsp_next.value_ready = 1'b0;
                rsp_next.status      = STAT_OK;
                rsp_next.last        = (src_n == 3'd1);
                busy_next            = (src_n != 3'd1);
                rem_next             = src_n - 1'b1;
                val_next             = src_val;
            end
            else
            begin
                rsp_next.out_byte    = '0;
                rsp_next.out_value   = head.value;
                rsp_next.value_ready = head.value_ready;
                rsp_next.status      = head.status;
                rsp_next.last        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
            if (adv)
                out_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rsp_reg <= rsp_next;
    end

    `SDNV_ASSERT(a_busy_rem, busy_reg |-> (rem_reg != '0 && rem_reg < 3'(MAX_BYTES)), "encode byte count out of range")
    `SDNV_ASSERT(a_busy_hold, (busy_reg && !adv) |=> (busy_reg && $stable(rem_reg)), "encode state moved while stalled")
    `SDNV_ASSERT(a_ready_last, (out_valid_reg && rsp_reg.value_ready) |-> rsp_reg.last, "decoded value not marked last")
    `SDNV_NEVER(a_busy_cont, out_valid_reg && !rsp_reg.last && (rsp_reg.out_byte[BYTE_W-1] == 1'b0), "continuation byte without flag")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import sdnv_pkg::*;

    localparam int CONT_LIMIT  = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 20;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      push  = 1'b0;
    logic      pop   = 1'b0;
    logic      full;
    logic      empty;
    sdnv_req_t req   = '0;
    sdnv_rsp_t rsp;

    // items waiting to be pushed, results still owed by the codec
    sdnv_req_t pending_req[$];
    sdnv_rsp_t rsp_expected[$];

    // decode state mirrored from the codec
    logic [VALUE_W-1:0] dec_acc = '0;
    logic [CNT_W-1:0]   dec_cnt = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_errors       = 0;
    int cycles         = 0;

    sdnv_codec #(
        .MAX_CONTINUATION(CONT_LIMIT)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // number of 7-bit groups for v, at least one
    function automatic int group_count(input logic [VALUE_W-1:0] v);
        int nbits;
        nbits = 0;
        while (v != '0)
        begin
            nbits++;
            v = v >> 1;
        end
        return (nbits == 0) ? 1 : (nbits + 6) / 7;
    endfunction

    // byte idx of the n-byte encoding of v, most significant first
    function automatic logic [BYTE_W-1:0] sdnv_byte(input logic [VALUE_W-1:0] v,
                                                    input int n, input int idx);
        logic [BYTE_W-1:0] b;
        b = {1'b0, 7'((v >> (7 * (n - 1 - idx))) & 32'h7F)};
        if (idx != n - 1)
            b = b | CONT_FLAG;
        return b;
    endfunction

    // expected results of one accepted item
    task automatic predict_item(input sdnv_req_t r);
        sdnv_rsp_t          res;
        logic [VALUE_W-1:0] nxt;
        int                 n;
        if (r.action == ACT_DECODE)
        begin
            nxt = {dec_acc[VALUE_W-GROUP_W-1:0], r.in_byte[GROUP_W-1:0]};
            res = '0;
            res.status = STAT_OK;
            res.last = 1'b1;
            if ((r.in_byte & CONT_FLAG) == '0)
            begin
                res.out_value = nxt;
                res.value_ready = 1'b1;
                dec_acc = '0;
                dec_cnt = '0;
            end
            else if (int'(dec_cnt) + 1 > CONT_LIMIT)
            begin
                res.status = STAT_TOO_LONG;
                dec_acc = '0;
                dec_cnt = '0;
            end
            else
            begin
                dec_acc = nxt;
                dec_cnt = dec_cnt + 1'b1;
            end
            rsp_expected.push_back(res);
        end
        else
        begin
            n = group_count(r.in_value);
            for (int i = 0; i < n; i++)
            begin
                res = '0;
                res.status = STAT_OK;
                res.out_byte = sdnv_byte(r.in_value, n, i);
                res.last = (i == n - 1);
                rsp_expected.push_back(res);
            end
        end
    endtask

    task automatic check_result(input sdnv_rsp_t got);
        sdnv_rsp_t want;
        if (rsp_expected.size() == 0)
        begin
            $error("unexpected item: out_byte %0h out_value %0h", got.out_byte, got.out_value);
            n_errors++;
        end
        else
        begin
            want = rsp_expected.pop_front();
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                n_errors++;
            end
            if (got.out_value !== want.out_value)
            begin
                $error("out_value: expected %0h, got %0h", want.out_value, got.out_value);
                n_errors++;
            end
            if (got.value_ready !== want.value_ready)
            begin
                $error("value_ready: expected %0b, got %0b", want.value_ready, got.value_ready);
                n_errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0b, got %0b", want.status, got.status);
                n_errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                n_errors++;
            end
        end
    endtask

    // driver: predict on acceptance, then offer the next pending item
    always @(posedge clk)
    begin : driver
        logic go;
        if (rst_n)
        begin
            if (push && !full)
            begin
                predict_item(req);
                void'(pending_req.pop_front());
            end
            go = (pending_req.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct);
            push <= go;
            if (go)
                req <= pending_req[0];
        end
    end

    // monitor: check each popped result, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_result(rsp);
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_decode(input logic [BYTE_W-1:0] b);
        sdnv_req_t r;
        r.action = ACT_DECODE;
        r.in_byte = b;
        r.in_value = $urandom;
        pending_req.push_back(r);
    endtask

    task automatic add_encode(input logic [VALUE_W-1:0] v);
        sdnv_req_t r;
        r.action = ACT_ENCODE;
        r.in_byte = 8'($urandom);
        r.in_value = v;
        pending_req.push_back(r);
    endtask

    function automatic logic [VALUE_W-1:0] rand_value();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // mostly well-formed numbers, with encodes, noise and overlong runs mixed in
    task automatic add_random(input int count);
        int                 start;
        int                 kind;
        int                 n;
        logic [VALUE_W-1:0] v;
        start = pending_req.size();
        while (pending_req.size() - start < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 3)
            begin
                v = rand_value();
                n = group_count(v);
                for (int i = 0; i < n; i++)
                begin
                    add_decode(sdnv_byte(v, n, i));
                    // an encode in mid-number must not disturb decoding
                    if (i == 0 && n > 1 && $urandom_range(0, 3) == 0)
                        add_encode(rand_value());
                end
            end
            else if (kind <= 5)
                add_encode(rand_value());
            else if (kind == 6)
                add_decode(8'($urandom));
            else if (kind == 7)
            begin
                n = $urandom_range(4, 6);
                for (int i = 0; i < n; i++)
                    add_decode(CONT_FLAG | 8'($urandom));
                add_decode(8'($urandom_range(0, 127)));
            end
            else
            begin
                // number of two to five bytes, upper bits may fall off the top
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    add_decode(CONT_FLAG | 8'($urandom));
                add_decode(8'($urandom_range(0, 127)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_req.size() != 0 || rsp_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        add_random(count);
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // encode size boundaries
        add_encode(32'h0000_0000);
        add_encode(32'h0000_007F);
        add_encode(32'h0000_0080);
        add_encode(32'h0FFF_FFFF);
        add_encode(32'h1000_0000);
        add_encode(32'h8000_0000);
        add_encode(32'hFFFF_FFFF);
        // single-byte numbers
        add_decode(8'h00);
        add_decode(8'h7F);
        // two-byte number
        add_decode(8'h81);
        add_decode(8'h00);
        // continuation limit reached, encode in between keeps decode state
        add_decode(8'h80);
        add_decode(8'h80);
        add_decode(8'h80);
        add_decode(8'h80);
        add_encode(32'h0000_3FFF);
        add_decode(8'hFF);
        // five-byte number overflowing 32 bits
        add_decode(8'hFF);
        add_decode(8'hFF);
        add_decode(8'hFF);
        add_decode(8'hFF);
        add_decode(8'h7F);
        wait_drained();

        run_phase(0, 0, 26);
        run_phase(55, 0, 26);
        run_phase(0, 55, 26);
        run_phase(19, 19, 26);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0 && rsp_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
